@@ rtl/u8ke_pkg.sv @@
// Shared types and constants of the UTF-8 to key event converter.
package u8ke_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ScanW     = 9;
  localparam int unsigned KeyW      = 16;
  localparam int unsigned PointW    = 21;
  localparam int unsigned LeftW     = 2;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CountW    = 2;
  localparam int unsigned OutDataW  = 24;

  localparam logic [ScanW-1:0] EnterScanReset = 9'd28;

  localparam logic [KindW-1:0] KIND_SCANCODE = 2'd0;
  localparam logic [KindW-1:0] KIND_UNICODE  = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR    = 2'd2;

  localparam logic [PointW-1:0] CodeCr     = 21'h00000D;
  localparam logic [PointW-1:0] CodeLf     = 21'h00000A;
  localparam logic [PointW-1:0] CodeBmpMax = 21'h00FFFF;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             released;
    logic [KeyW-1:0]  key_code;
    logic             last;
  } result_t;

  // Up to two results caused by one byte, in the order they leave.
  typedef struct packed {
    result_t           res0;
    result_t           res1;
    logic [CountW-1:0] count;
  } pair_t;

endpackage

@@ rtl/u8ke_decoder.sv @@
// Byte-wise UTF-8 sequence decoder with the enter scancode register.
module u8ke_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [u8ke_pkg::ScanW-1:0]    cfg_wdata_i,
  input  logic                          take_i,
  input  logic [u8ke_pkg::ByteW-1:0]    byte_i,
  input  logic                          end_i,
  output u8ke_pkg::pair_t               pair_o
);
  import u8ke_pkg::*;

  logic [ScanW-1:0]  enter_scan_q;
  logic [PointW-1:0] point_q, point_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic              drop_q, drop_d;

  logic [PointW-1:0] shifted;
  logic [LeftW-1:0]  left_dec;
  logic              do_emit;
  logic [PointW-1:0] emit_point;
  logic              do_fault;

  assign shifted  = {point_q[PointW-7:0], byte_i[5:0]};
  assign left_dec = left_q - 2'd1;

  always_comb begin
    point_d    = point_q;
    left_d     = left_q;
    drop_d     = drop_q;
    do_emit    = 1'b0;
    do_fault   = 1'b0;
    emit_point = '0;
    if (drop_q) begin
      drop_d = !end_i;
    end else if (left_q == '0) begin
      if (byte_i[7] == 1'b0) begin
        do_emit    = 1'b1;
        emit_point = {{(PointW-ByteW){1'b0}}, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        point_d  = {{(PointW-5){1'b0}}, byte_i[4:0]};
        left_d   = 2'd1;
        do_fault = end_i;
      end else if (byte_i[7:4] == 4'b1110) begin
        point_d  = {{(PointW-4){1'b0}}, byte_i[3:0]};
        left_d   = 2'd2;
        do_fault = end_i;
      end else if (byte_i[7:3] == 5'b11110) begin
        point_d  = {{(PointW-3){1'b0}}, byte_i[2:0]};
        left_d   = 2'd3;
        do_fault = end_i;
      end else begin
        do_fault = 1'b1;
      end
    end else if (byte_i[7:6] != 2'b10) begin
      do_fault = 1'b1;
    end else begin
      point_d = shifted;
      left_d  = left_dec;
      if (left_dec == '0) begin
        do_emit    = 1'b1;
        emit_point = shifted;
      end else begin
        do_fault = end_i;
      end
    end

    pair_o = '0;
    if (do_emit) begin
      point_d = '0;
      left_d  = '0;
      if (emit_point == CodeCr || emit_point == CodeLf) begin
        pair_o.res0  = '{kind: KIND_SCANCODE, released: 1'b0,
                         key_code: {{(KeyW-ScanW){1'b0}}, enter_scan_q}, last: 1'b0};
        pair_o.res1  = '{kind: KIND_SCANCODE, released: 1'b1,
                         key_code: {{(KeyW-ScanW){1'b0}}, enter_scan_q}, last: 1'b1};
        pair_o.count = 2'd2;
      end else if (emit_point > CodeBmpMax) begin
        do_fault = 1'b1;
      end else begin
        pair_o.res0  = '{kind: KIND_UNICODE, released: 1'b0,
                         key_code: emit_point[KeyW-1:0], last: 1'b0};
        pair_o.res1  = '{kind: KIND_UNICODE, released: 1'b1,
                         key_code: emit_point[KeyW-1:0], last: 1'b1};
        pair_o.count = 2'd2;
      end
    end
    if (do_fault) begin
      point_d      = '0;
      left_d       = '0;
      drop_d       = !end_i;
      pair_o       = '0;
      pair_o.res0  = '{kind: KIND_ERROR, released: 1'b0, key_code: '0, last: 1'b1};
      pair_o.count = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_scan_q <= EnterScanReset;
      point_q      <= '0;
      left_q       <= '0;
      drop_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enter_scan_q <= cfg_wdata_i;
      end
      if (take_i) begin
        point_q <= point_d;
        left_q  <= left_d;
        drop_q  <= drop_d;
      end
    end
  end

endmodule

@@ rtl/u8ke_out_buf.sv @@
// Two-entry result register that drains one result per transfer.
module u8ke_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  u8ke_pkg::pair_t     pair_i,
  output logic                can_load_o,
  output logic                valid_o,
  input  logic                ready_i,
  output u8ke_pkg::result_t   res_o
);
  import u8ke_pkg::*;

  result_t           slot0_q, slot1_q;
  logic [CountW-1:0] count_q;
  logic              pop;

  assign valid_o    = (count_q != '0);
  assign pop        = valid_o && ready_i;
  assign res_o      = slot0_q;
  // A new pair may enter when the buffer is empty or its last entry leaves now.
  assign can_load_o = (count_q == '0) || (count_q == 2'd1 && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (load_i) begin
      count_q <= pair_i.count;
    end else if (pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= pair_i.res0;
      slot1_q <= pair_i.res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

@@ rtl/utf8_to_key_events_core.sv @@
// UTF-8 byte stream to key press and release events, top level.
// Each accepted byte is decoded in the cycle of its transfer and its results appear on the
// master side from the next cycle on. A byte may yield no result or one result (a
// continuation, a dropped byte, an error); a character up to U+FFFF yields a press and a
// release, which leave one after the other over the single master port. The next byte
// is taken in the cycle the last pending result transfers, so no cycle is lost between
// bytes. The enter scancode register may be written only while no results are pending.
module utf8_to_key_events_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] released, [16:1] key_code, [23:17] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast    // last_of_run
);
  import u8ke_pkg::*;

  pair_t   pair;
  result_t res;
  logic    take;

  assign take = s_axis_tvalid && s_axis_tready;

  u8ke_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .byte_i      (s_axis_tdata),
    .end_i       (s_axis_tlast),
    .pair_o      (pair)
  );

  u8ke_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take),
    .pair_i     (pair),
    .can_load_o (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {{(OutDataW-KeyW-1){1'b0}}, res.key_code, res.released};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

@@ rtl/u8ke_checker.sv @@
// Port-level checker for the UTF-8 to key event converter, with its bind.
module u8ke_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import u8ke_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // An error result is a lone, empty, final result.
  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |->
      (m_axis_tlast && m_axis_tdata == '0))
    else $error("malformed error result");

  // Key events: a release closes the run, a press never does.
  a_release_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_ERROR) |-> (m_axis_tlast == m_axis_tdata[0]))
    else $error("tlast does not match press or release");

  // The release that follows a press is already buffered.
  a_press_then_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser != KIND_ERROR && !m_axis_tdata[0])
      |=> (m_axis_tvalid && m_axis_tdata[0]))
    else $error("press not followed by its release");

  // Input is held back only while results are pending.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind utf8_to_key_events_core u8ke_checker u_u8ke_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for the UTF-8 to key event converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8ke_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned PhaseBytes  = 195;
  localparam int unsigned SettleWait  = 4;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  utf8_to_key_events_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Decoder state as the block should hold it.
  logic [ScanW-1:0]  enter_code = EnterScanReset;
  logic [PointW-1:0] acc_point  = '0;
  logic [LeftW-1:0]  cont_left  = '0;
  logic              skipping   = 1'b0;

  result_t     events_due[$];
  int unsigned mismatch_count = 0;
  int unsigned live_bytes     = 0;
  int unsigned cycle_count    = 0;
  int          burst_left     = 0;
  bit          sender_steady  = 1'b0;

  function automatic result_t key_event(input logic [KindW-1:0] kind, input logic rel,
                                        input logic [KeyW-1:0] code, input logic last);
    result_t r;
    r.kind     = kind;
    r.released = rel;
    r.key_code = code;
    r.last     = last;
    return r;
  endfunction

  function automatic void add_due(input result_t r);
    events_due = {events_due, r};
  endfunction

  function automatic void decode_fault(input logic eot);
    acc_point = '0;
    cont_left = '0;
    skipping  = !eot;
    add_due(key_event(KIND_ERROR, 1'b0, '0, 1'b1));
  endfunction

  function automatic void emit_char(input logic [PointW-1:0] cp, input logic eot);
    acc_point = '0;
    cont_left = '0;
    if (cp == CodeCr || cp == CodeLf) begin
      add_due(key_event(KIND_SCANCODE, 1'b0, KeyW'(enter_code), 1'b0));
      add_due(key_event(KIND_SCANCODE, 1'b1, KeyW'(enter_code), 1'b1));
    end else if (cp > CodeBmpMax) begin
      decode_fault(eot);
    end else begin
      add_due(key_event(KIND_UNICODE, 1'b0, cp[KeyW-1:0], 1'b0));
      add_due(key_event(KIND_UNICODE, 1'b1, cp[KeyW-1:0], 1'b1));
    end
  endfunction

  function automatic void predict_text_byte(input logic [7:0] b, input logic eot);
    if (skipping) begin
      if (eot) skipping = 1'b0;
    end else if (cont_left == 0) begin
      if (!b[7]) begin
        emit_char(PointW'(b), eot);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        if (b[7:5] == 3'b110) begin
          acc_point = PointW'(b[4:0]);
          cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_point = PointW'(b[3:0]);
          cont_left = 2'd2;
        end else begin
          acc_point = PointW'(b[2:0]);
          cont_left = 2'd3;
        end
        // A lead byte on the last byte of a text leaves the sequence open.
        if (eot) decode_fault(eot);
      end else begin
        decode_fault(eot);
      end
    end else if (b[7:6] != 2'b10) begin
      decode_fault(eot);
    end else begin
      acc_point = {acc_point[PointW-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) emit_char(acc_point, eot);
      else if (eot) decode_fault(eot);
    end
  endfunction

  // Receiver: ready pattern that changes character every stretch of cycles.
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_events
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = key_event(m_axis_tuser, m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tlast);
      if (events_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported)
          $display("unexpected event: kind %0d rel %0d code %h last %0d",
                   got.kind, got.released, got.key_code, got.last);
      end else begin
        want = events_due.pop_front();
        if (got !== want || m_axis_tdata[23:17] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("event mismatch: expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d pad %h",
                     want.kind, want.released, want.key_code, want.last,
                     got.kind, got.released, got.key_code, got.last, m_axis_tdata[23:17]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!skipping) live_bytes++;
    predict_text_byte(b, eot);
  endtask

  // Stops the sender and lets every pending event leave.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (events_due.size() != 0);
  endtask

  task automatic write_enter_code(input logic [ScanW-1:0] value);
    wait_drained();
    repeat (SettleWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    enter_code  = value;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_random_text();
    logic [7:0] txt[$];
    int         chars;
    int         pick;
    logic [7:0] c;
    chars = $urandom_range(1, 6);
    repeat (chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        c = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? 8'h0D : 8'h0A;
        txt = {txt, c};
      end else if (pick < 55) begin
        txt = {txt, 8'hC0 | 8'($urandom_range(0, 31))};
        txt = {txt, cont_byte()};
      end else if (pick < 75) begin
        txt = {txt, 8'hE0 | 8'($urandom_range(0, 15))};
        txt = {txt, cont_byte()};
        txt = {txt, cont_byte()};
      end else if (pick < 92) begin
        // Half the leads are F0; with a low next byte, these fit in 16 bits.
        txt = {txt, ($urandom_range(0, 1) ? 8'hF0 : (8'hF0 | 8'($urandom_range(0, 7))))};
        txt = {txt, (8'h80 | ($urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                   : 8'($urandom_range(0, 63))))};
        txt = {txt, cont_byte()};
        txt = {txt, cont_byte()};
      end else begin
        txt = {txt, 8'($urandom_range(0, 255))};
      end
    end
    pick = $urandom_range(0, 9);
    if (pick == 0 && txt.size() > 1) void'(txt.pop_back());
    else if (pick == 1) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic test_decode_cases();
    // Single-byte extremes and both enter characters.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0A, 1'b1);
    // Multi-byte sequences at the edges of their ranges, overlong forms accepted.
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h8D, 1'b1);
    // Code point above 16 bits on the last byte of a text.
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // Stray continuation as a lead byte, then the rest of the text is dropped.
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // Invalid lead byte that also ends the text.
    send_byte(8'hF8, 1'b1);
    // Broken continuation; the ASCII byte is not taken as a new lead.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    // Text ending in the middle of a sequence.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  task automatic test_enter_scancode();
    logic [ScanW-1:0] codes[3];
    codes[0] = '0;
    codes[1] = '1;
    codes[2] = ScanW'($urandom_range(1, 510));
    foreach (codes[i]) begin
      write_enter_code(codes[i]);
      send_byte(8'h0D, 1'b0);
      send_byte(8'h0A, 1'b1);
    end
  endtask

  task automatic test_random_text(input bit steady);
    int unsigned stop_at;
    bit          paused;
    sender_steady = steady;
    stop_at       = live_bytes + PhaseBytes;
    paused        = 1'b0;
    while (live_bytes < stop_at) begin
      send_random_text();
      if (!paused && live_bytes + PhaseBytes / 2 >= stop_at) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_decode_cases();
    test_enter_scancode();
    write_enter_code(EnterScanReset);
    test_random_text(1'b0);
    write_enter_code(ScanW'($urandom_range(0, 511)));
    test_random_text(1'b1);
    write_enter_code('1);
    test_random_text(1'b0);
    write_enter_code(ScanW'($urandom_range(0, 511)));
    test_random_text(1'b0);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/u8ke_pkg.sv
rtl/u8ke_decoder.sv
rtl/u8ke_out_buf.sv
rtl/utf8_to_key_events_core.sv
rtl/u8ke_checker.sv
bench/tb.sv
